@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion shorthands, clocked on clk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ rtl/mbe_pkg.sv @@
// ----------------------------------------------------------------------------
// mbe_pkg
// types and constants of the mask boundary erosion block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

  localparam int TYPE_BITS         = 2;
  localparam int HEIGHT_BITS       = 32;
  localparam int IMAGE_WIDTH_BITS  = 11;
  localparam int IMAGE_HEIGHT_BITS = 13;
  localparam int CFG_DATA_BITS     = 13;
  localparam int TDATA_BITS        = 40;

  typedef logic [TYPE_BITS-1:0] px_type_t;

  // class codes, two's complement
  localparam px_type_t TYPE_OTHER      = 2'b00;
  localparam px_type_t TYPE_OBJECT     = 2'b01;
  localparam px_type_t TYPE_BACKGROUND = 2'b11;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // one image column of the 3x3 window, top is the oldest row
  typedef struct packed {
    px_type_t top;
    px_type_t mid;
    px_type_t bot;
  } column_t;

  // where the window center sits relative to the image border
  typedef struct packed {
    logic has_out;
    logic up_ok;
    logic down_ok;
    logic left_ok;
    logic right_ok;
    logic frame_end;
  } win_ctl_t;

endpackage

`default_nettype wire

@@ rtl/mbe_ram.sv @@
// ----------------------------------------------------------------------------
// mbe_ram
// simple dual-port ram, one write and one registered read, read-first
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbe_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/mask_boundary_erosion_3x3.sv @@
// ----------------------------------------------------------------------------
// mask_boundary_erosion_3x3
// 3x3 8-connected erosion of an object mask in a raster pixel stream
// ----------------------------------------------------------------------------
// usage
//   in_*  : one pixel per transaction in raster order; tuser set marks a drain
//           transaction that carries no pixel
//   out_* : eroded pixel, tlast on the last pixel of the frame
//   cfg_* : image size, write only while the block is idle; a write restarts
//           the frame position
// an object pixel with a background 8-neighbor inside the image leaves as
// background with height zero, everything else passes unchanged
// throughput: one transaction per cycle when not stalled, set by the line ram,
// which is read and written back at one column address per transaction
// results: the result for a pixel comes with the input transaction image_width+1
// places later and reaches out_* through the ram stage and the output register;
// the host sends image_width+1 drain transactions after each frame
// reset: position back to the frame start, pipeline and output empty, size
// registers at 1024 x 1024 (clipped to the maximum); the line ram needs no clear
// stall: a result waits in the output register while the next input is taken;
// with that register not taken and a result in the ram stage, in_tready drops
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mask_boundary_erosion_3x3
  import mbe_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // in_tdata: [1:0] pixel_type, [33:2] height_bits, rest zero
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [TDATA_BITS-1:0]    in_tdata,
  // in_tuser: [0] drain
  input  logic                     in_tuser,
  // out_tdata: [1:0] out_type, [33:2] out_height, rest zero
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [TDATA_BITS-1:0]    out_tdata,
  output logic                     out_tlast,
  input  logic                     cfg_wen,
  input  logic [0:0]               cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int RW        = $clog2(MAX_HEIGHT + 2);
  localparam int WORD_BITS = HEIGHT_BITS + 2 * TYPE_BITS;
  localparam int PAD_BITS  = TDATA_BITS - HEIGHT_BITS - TYPE_BITS;
  localparam int RST_W     = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
  localparam int RST_H     = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;

  // ------------------------------------------------------------------
  // size registers and frame position
  // ------------------------------------------------------------------
  logic [CW-1:0] wm1_r, wm1_nxt;          // image width minus one
  logic [RW-1:0] height_r, height_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;          // runs to height+1 for the drain row

  logic [31:0] w_val, h_val, w_clamp, h_clamp;
  logic        cfg_hit;

  always_comb begin
    w_val = 32'(cfg_wdata[IMAGE_WIDTH_BITS-1:0]);
    h_val = 32'(cfg_wdata[IMAGE_HEIGHT_BITS-1:0]);
    // zero reads as one, too large reads as the maximum
    if (w_val == 32'd0) begin
      w_clamp = 32'd1;
    end else if (w_val > 32'(MAX_WIDTH)) begin
      w_clamp = 32'(MAX_WIDTH);
    end else begin
      w_clamp = w_val;
    end
    if (h_val == 32'd0) begin
      h_clamp = 32'd1;
    end else if (h_val > 32'(MAX_HEIGHT)) begin
      h_clamp = 32'(MAX_HEIGHT);
    end else begin
      h_clamp = h_val;
    end
  end

  always_comb begin
    wm1_nxt    = wm1_r;
    height_nxt = height_r;
    cfg_hit    = 1'b0;
    if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH: begin
          wm1_nxt = CW'(w_clamp - 32'd1);
          cfg_hit = 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          height_nxt = RW'(h_clamp);
          cfg_hit    = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // window center position relative to the input position:
  // one row and one column back, or two rows back at the last column
  logic [RW-1:0] h_plus1;
  logic          col_zero, last_col;
  logic          row_ge1, row_ge2, row_ge3, row_le_h, row_lt_h, row_le_h1, row_eq_h1;
  win_ctl_t      ctl_in;

  always_comb begin
    h_plus1   = height_r + RW'(1);
    col_zero  = (col_r == '0);
    last_col  = (col_r == wm1_r);
    row_ge1   = (row_r != '0);
    row_ge2   = (row_r >= RW'(2));
    row_ge3   = (row_r >= RW'(3));
    row_le_h  = (row_r <= height_r);
    row_lt_h  = (row_r < height_r);
    row_le_h1 = (row_r <= h_plus1);
    row_eq_h1 = (row_r == h_plus1);
    if (col_zero) begin
      ctl_in.has_out   = row_ge2 && row_le_h1;
      ctl_in.up_ok     = row_ge3;
      ctl_in.down_ok   = row_le_h;
      ctl_in.left_ok   = (wm1_r != '0);
      ctl_in.right_ok  = 1'b0;
      ctl_in.frame_end = row_eq_h1;
    end else begin
      ctl_in.has_out   = row_ge1 && row_le_h;
      ctl_in.up_ok     = row_ge2;
      ctl_in.down_ok   = row_lt_h;
      ctl_in.left_ok   = (col_r >= CW'(2));
      ctl_in.right_ok  = 1'b1;
      ctl_in.frame_end = 1'b0;
    end
  end

  // ------------------------------------------------------------------
  // handshake
  // ------------------------------------------------------------------
  logic     b_valid_r, b_valid_nxt;
  win_ctl_t b_ctl_r;
  logic     out_valid_r, out_valid_nxt;
  logic     b_move, in_acc;

  assign b_move    = b_valid_r && (!b_ctl_r.has_out || !out_valid_r || out_tready);
  assign in_tready = !b_valid_r || b_move;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_acc) begin
      if (ctl_in.frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (last_col) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (in_acc) begin
      b_valid_nxt = 1'b1;
    end else if (b_move) begin
      b_valid_nxt = 1'b0;
    end
  end

  // ------------------------------------------------------------------
  // ram stage: column word {height(row-1), type(row-1), type(row-2)}
  // ------------------------------------------------------------------
  logic [CW-1:0]          b_col_r;
  px_type_t               b_t_r;
  logic [HEIGHT_BITS-1:0] b_h_r;
  logic [WORD_BITS-1:0]   ram_rdata, ram_q, ram_wdata;
  logic                   fwd_sel_r;
  logic [WORD_BITS-1:0]   fwd_data_r;

  mbe_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (b_move),
    .waddr (b_col_r),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // one-pixel-wide image reads the entry written in the same cycle
  assign ram_q     = fwd_sel_r ? fwd_data_r : ram_rdata;
  assign ram_wdata = {b_h_r, b_t_r, ram_q[2*TYPE_BITS-1:TYPE_BITS]};

  // ------------------------------------------------------------------
  // 3x3 window: current, center and left columns
  // ------------------------------------------------------------------
  column_t                cur_col;
  column_t                prev_col_r, left_col_r;
  logic [HEIGHT_BITS-1:0] prev_h_r;
  logic                   nb_bg, erode;

  always_comb begin
    cur_col.top = ram_q[TYPE_BITS-1:0];
    cur_col.mid = ram_q[2*TYPE_BITS-1:TYPE_BITS];
    cur_col.bot = b_t_r;

    nb_bg = 1'b0;
    if (b_ctl_r.up_ok) begin
      nb_bg = nb_bg || (prev_col_r.top == TYPE_BACKGROUND)
                    || (b_ctl_r.left_ok && (left_col_r.top == TYPE_BACKGROUND))
                    || (b_ctl_r.right_ok && (cur_col.top == TYPE_BACKGROUND));
    end
    nb_bg = nb_bg || (b_ctl_r.left_ok && (left_col_r.mid == TYPE_BACKGROUND))
                  || (b_ctl_r.right_ok && (cur_col.mid == TYPE_BACKGROUND));
    if (b_ctl_r.down_ok) begin
      nb_bg = nb_bg || (prev_col_r.bot == TYPE_BACKGROUND)
                    || (b_ctl_r.left_ok && (left_col_r.bot == TYPE_BACKGROUND))
                    || (b_ctl_r.right_ok && (cur_col.bot == TYPE_BACKGROUND));
    end
    erode = (prev_col_r.mid == TYPE_OBJECT) && nb_bg;
  end

  // ------------------------------------------------------------------
  // output register
  // ------------------------------------------------------------------
  px_type_t               out_type_r;
  logic [HEIGHT_BITS-1:0] out_height_r;
  logic                   out_fe_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (b_move && b_ctl_r.has_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_BITS{1'b0}}, out_height_r, out_type_r};
  assign out_tlast  = out_fe_r;

  // ------------------------------------------------------------------
  // registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r       <= CW'(RST_W - 1);
      height_r    <= RW'(RST_H);
      col_r       <= '0;
      row_r       <= '0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_sel_r   <= 1'b0;
    end else begin
      wm1_r       <= wm1_nxt;
      height_r    <= height_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        fwd_sel_r <= b_move && (b_col_r == col_r);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_col_r    <= col_r;
      b_ctl_r    <= ctl_in;
      b_t_r      <= in_tuser ? TYPE_OTHER : in_tdata[TYPE_BITS-1:0];
      b_h_r      <= in_tuser ? '0 : in_tdata[TYPE_BITS +: HEIGHT_BITS];
      fwd_data_r <= ram_wdata;
    end
    if (b_move) begin
      left_col_r <= prev_col_r;
      prev_col_r <= cur_col;
      prev_h_r   <= ram_q[WORD_BITS-1:2*TYPE_BITS];
    end
    if (b_move && b_ctl_r.has_out) begin
      out_type_r   <= erode ? TYPE_BACKGROUND : prev_col_r.mid;
      out_height_r <= erode ? '0 : prev_h_r;
      out_fe_r     <= b_ctl_r.frame_end;
    end
  end

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  `ASSERT_ALWAYS(a_col_in_row, col_r <= wm1_r, "column position past image width")
  `ASSERT_ALWAYS(a_row_in_frame, row_r <= h_plus1, "row position past drain row")
  `ASSERT_IMPLY(a_stall_cause, !in_tready, b_valid_r && out_valid_r && !out_tready,
                "input stalled without a blocked result")
  `ASSERT_NEXT(a_result_kept, b_move && b_ctl_r.has_out, out_valid_r,
               "result from ram stage not loaded into output register")

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the 3x3 boundary erosion block against a cycle-free model of the
// mask stream: directed corner frames, extreme image shapes, random frames
// under random input gaps and output stalls, and a long output hold-off
// that makes the block stall its input
// ----------------------------------------------------------------------------
module testbench;
  import mbe_pkg::*;

  localparam int MAX_W       = 1024;
  localparam int MAX_H       = 4096;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 460;

  // class code with no meaning, must pass through untouched
  localparam px_type_t TYPE_RESERVED = 2'b10;

  typedef struct {
    px_type_t    ptype;
    logic [31:0] height;
    logic        last;
  } eroded_px_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [TDATA_BITS-1:0]    in_tdata = '0;
  logic                     in_tuser = 1'b0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [TDATA_BITS-1:0]    out_tdata;
  logic                     out_tlast;
  logic                     cfg_wen = 1'b0;
  logic [0:0]               cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  mask_boundary_erosion_3x3 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // mask model: four row buffers indexed by row modulo four, plus the stream
  // position of the next input transaction inside the frame
  // ---------------------------------------------------------------------------
  px_type_t    class_ring  [0:3][0:MAX_W-1];
  logic [31:0] height_ring [0:3][0:MAX_W-1];
  int          img_w = 1024;
  int          img_h = 1024;
  int          pos_col = 0;
  int          pos_row = 0;

  eroded_px_t  eroded_q[$];

  // bookkeeping
  int cycles = 0;
  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int frames_done = 0;
  int eroded_seen = 0;
  int in_stalls = 0;

  // sender burst state
  bit idle_on = 1'b0;
  int burst_left = 0;

  // receiver hold-off request, picked up by the receiver process
  bit hold_req = 1'b0;
  int hold_len = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_tick = 0;
  logic [6:0] rx_pattern = 7'b1011001;

  // one input transaction through the model; queues the result it causes
  task automatic erode_predict(input px_type_t ptype, input logic [31:0] hbits,
                               input logic drain);
    int r, c, qr, qc, nr, nc;
    px_type_t t;
    logic [31:0] hv;
    eroded_px_t res;
    bit ended;
    r = pos_row;
    c = pos_col;
    ended = 1'b0;
    if (c >= img_w) c = img_w - 1;
    // positions past the last pixel are drain whatever the tuser bit says
    if (r < img_h) begin
      class_ring[r % 4][c]  = drain ? TYPE_OTHER : ptype;
      height_ring[r % 4][c] = drain ? 32'd0 : hbits;
    end
    // the result is for the pixel one row and one column behind
    if (c >= 1) begin
      qc = c - 1;
      qr = r - 1;
    end else begin
      qc = img_w - 1;
      qr = r - 2;
    end
    if (qr >= 0 && qr < img_h) begin
      t  = class_ring[qr % 4][qc];
      hv = height_ring[qr % 4][qc];
      if (t == TYPE_OBJECT) begin
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            nr = qr + dr;
            nc = qc + dc;
            if (nr >= 0 && nr < img_h && nc >= 0 && nc < img_w) begin
              if (class_ring[nr % 4][nc] == TYPE_BACKGROUND) begin
                t  = TYPE_BACKGROUND;
                hv = 32'd0;
              end
            end
          end
        end
        if (t == TYPE_BACKGROUND) eroded_seen++;
      end
      res.ptype  = t;
      res.height = hv;
      res.last   = (qr == img_h - 1 && qc == img_w - 1);
      eroded_q.insert(eroded_q.size(), res);
      ended = res.last;
    end
    if (ended) begin
      pos_col = 0;
      pos_row = 0;
      frames_done++;
    end else begin
      c++;
      if (c >= img_w) begin
        c = 0;
        r++;
      end
      pos_col = c;
      pos_row = r;
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one input transaction, with a random gap between bursts when idling is on
  task automatic send_item(input px_type_t ptype, input logic [31:0] hbits,
                           input logic drain);
    int gap;
    if (idle_on && burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(TDATA_BITS-2-32){1'b0}}, hbits, ptype};
    in_tuser  <= drain;
    do @(posedge clk); while (!in_tready);
    erode_predict(ptype, hbits, drain);
    items_sent++;
  endtask

  // drop valid and let every expected result come out of the block
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (eroded_q.size() != 0) @(posedge clk);
    // pipeline is two stages deep, the extra wait below covers it
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
    int v;
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    // zero reads as one, anything above the maximum is clipped
    if (idx == REG_IMAGE_WIDTH) begin
      v = int'(val[IMAGE_WIDTH_BITS-1:0]);
      img_w = (v == 0) ? 1 : (v > MAX_W) ? MAX_W : v;
    end else begin
      v = int'(val[IMAGE_HEIGHT_BITS-1:0]);
      img_h = (v == 0) ? 1 : (v > MAX_H) ? MAX_H : v;
    end
    pos_col = 0;
    pos_row = 0;
  endtask

  function automatic px_type_t pick_type(input int obj_pct);
    if ($urandom_range(0, 99) < obj_pct) return TYPE_OBJECT;
    case ($urandom_range(0, 3))
      0, 1:    return TYPE_BACKGROUND;
      2:       return TYPE_OTHER;
      default: return TYPE_RESERVED;
    endcase
  endfunction

  // a whole frame at the current size, then the drain tail that flushes it;
  // a quarter of the tail carries pixel data with tuser low
  task automatic send_frame(input int obj_pct, input int drain_pct);
    int n;
    n = img_w * img_h;
    for (int i = 0; i < n; i++)
      send_item(pick_type(obj_pct), $urandom(), $urandom_range(0, 99) < drain_pct);
    for (int i = 0; i <= img_w; i++)
      send_item(pick_type(obj_pct), $urandom(), $urandom_range(0, 3) != 0);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // zero sizes read as 1x1; a lone pixel has no neighbor and never erodes
  task automatic test_single_pixel();
    write_reg(REG_IMAGE_WIDTH, '0);
    write_reg(REG_IMAGE_HEIGHT, '0);
    send_item(TYPE_OBJECT, 32'hFFFF_FFFF, 1'b0);
    send_item(TYPE_OTHER, 32'h0, 1'b1);
    send_item(TYPE_OTHER, 32'h0, 1'b1);
    send_item(TYPE_BACKGROUND, 32'h0, 1'b0);
    send_item(TYPE_OBJECT, 32'hDEAD_BEEF, 1'b0);
    send_item(TYPE_RESERVED, 32'h1234_5678, 1'b1);
  endtask

  // 3x3 frame by hand: border objects next to background, a reserved code,
  // a drain inside the frame and pixel data in the tail
  task automatic test_small_frame();
    px_type_t    cls [0:8];
    logic [31:0] hgt [0:8];
    cls = '{TYPE_OBJECT, TYPE_OBJECT, TYPE_OBJECT,
            TYPE_OBJECT, TYPE_OBJECT, TYPE_BACKGROUND,
            TYPE_OBJECT, TYPE_RESERVED, TYPE_OBJECT};
    hgt = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0001,
            32'h7FFF_FFFE, 32'hA5A5_5A5A, 32'hFFFF_FFFF,
            32'h0000_FFFF, 32'hFFFF_0000, 32'h1};
    // upper write-data bits are outside the width register
    write_reg(REG_IMAGE_WIDTH, 13'h1803);
    write_reg(REG_IMAGE_HEIGHT, 13'd3);
    for (int i = 0; i < 9; i++)
      send_item(cls[i], hgt[i], i == 6);
    send_item(TYPE_OBJECT, 32'hFFFF_FFFF, 1'b0);
    send_item(TYPE_OTHER, 32'h0, 1'b1);
    send_item(TYPE_BACKGROUND, 32'h5555_AAAA, 1'b0);
    send_item(TYPE_OTHER, 32'h0, 1'b1);
  endtask

  // one long row, no row above or below any pixel
  task automatic test_widest_row();
    write_reg(REG_IMAGE_WIDTH, 13'd160);
    write_reg(REG_IMAGE_HEIGHT, 13'd1);
    send_frame(70, 3);
  endtask

  // one tall column, one pixel wide, the line ram reads what it just wrote
  task automatic test_tallest_column();
    write_reg(REG_IMAGE_WIDTH, 13'd1);
    write_reg(REG_IMAGE_HEIGHT, 13'd120);
    send_frame(75, 3);
  endtask

  // small random frames until the item budget is used up
  task automatic test_random_frames();
    int start;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0)
        write_reg(REG_IMAGE_WIDTH, 13'($urandom_range(17, 40)));
      else
        write_reg(REG_IMAGE_WIDTH, 13'($urandom_range(1, 16)));
      write_reg(REG_IMAGE_HEIGHT, 13'($urandom_range(1, 12)));
      // a few frames with no idling at all
      idle_on = ($urandom_range(0, 4) != 0);
      send_frame($urandom_range(40, 95), $urandom_range(0, 8));
    end
    idle_on = 1'b1;
  endtask

  // receiver holds off for a long time while the sender keeps offering
  task automatic test_backpressure();
    write_reg(REG_IMAGE_WIDTH, 13'd8);
    write_reg(REG_IMAGE_HEIGHT, 13'd8);
    idle_on = 1'b0;
    hold_len = 250;
    hold_req = 1'b1;
    send_frame(80, 2);
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stalls on a randomly picked mode, or holds off
  // for a counted stretch when asked
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = hold_len;
    end
    rx_tick++;
    if (rx_tick % 97 == 0) rx_mode = $urandom_range(0, 2);
    rx_pattern = {rx_pattern[5:0], rx_pattern[6]};
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= rx_pattern[0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // result check: each transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  eroded_px_t want;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && !in_tready) in_stalls++;
    if (rst_n && out_tvalid && out_tready) begin
      if (eroded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: type %b height %h last %b",
                   out_tdata[1:0], out_tdata[33:2], out_tlast);
      end else begin
        want = eroded_q.pop_front();
        results_checked++;
        if (out_tdata[1:0] !== want.ptype || out_tdata[33:2] !== want.height ||
            out_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected type %b height %h last %b, got %b %h %b",
                     results_checked, want.ptype, want.height, want.last,
                     out_tdata[1:0], out_tdata[33:2], out_tlast);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, eroded_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < MAX_W; c++) begin
        class_ring[r][c]  = TYPE_OTHER;
        height_ring[r][c] = 32'd0;
      end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part runs back to back, idling comes in afterwards
    test_single_pixel();
    test_small_frame();
    idle_on = 1'b1;
    test_widest_row();
    test_tallest_column();
    test_random_frames();
    test_backpressure();

    wait_idle();
    repeat (16) @(posedge clk);

    $display("ran %0d frames from 1x1 up to a 160-pixel row and a 120-row column, %0d inputs",
             frames_done, items_sent);
    $display("checked %0d results, %0d of them eroded, input stalled %0d cycles",
             results_checked, eroded_seen, in_stalls);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
